>>> rtl/core/kcl_pkg.sv
`timescale 1ns / 1ps

package kcl_pkg;

  // number of digits in a code
  localparam int CODE_DIGITS = 6;
  localparam int DIGIT_W     = 4;
  localparam int CNT_W       = $clog2(CODE_DIGITS + 1);
  localparam int IDX_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  // packed outputs carry at most six digits
  localparam int PACK_DIGITS = (CODE_DIGITS < 6) ? CODE_DIGITS : 6;

  localparam int CODE_W  = 24;
  localparam int HOLD_W  = 8;
  localparam int MODE_W  = 3;
  localparam int OCNT_W  = 3;
  localparam int KEY_W   = 4;
  localparam int IDATA_W = 8;
  localparam int ODATA_W = 56;

  localparam logic [CODE_W-1:0] DEFAULT_CODE_RST = 24'd8947848;
  localparam logic [HOLD_W-1:0] HOLD_SECONDS_RST = 8'd5;

  // configuration register indexes
  localparam logic CFG_DEFAULT_CODE = 1'b0;
  localparam logic CFG_HOLD_SECONDS = 1'b1;

  // modes
  localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ENTRY  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OPEN   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FAIL   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CHANGE = 3'd4;

  // word kinds
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // keys
  localparam logic [KEY_W-1:0] KEY_DIGIT0  = 4'd0;
  localparam logic [KEY_W-1:0] KEY_DIGIT9  = 4'd9;
  localparam logic [KEY_W-1:0] KEY_BACK    = 4'd10;
  localparam logic [KEY_W-1:0] KEY_CONFIRM = 4'd11;
  localparam logic [KEY_W-1:0] KEY_START   = 4'd12;
  localparam logic [KEY_W-1:0] KEY_CLEAR   = 4'd13;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [OCNT_W-1:0] entered_count;
    logic [CODE_W-1:0] entered_code;
    logic              relay_on;
    logic              save_strobe;
    logic [CODE_W-1:0] saved_code;
  } kcl_result_t;

endpackage

>>> rtl/core/keypad_code_lock_unit.sv
`timescale 1ns / 1ps
// The result word is registered at the edge that accepts the input word.
// Throughput: one word per cycle, set by the single mode-update stage ahead of the
//   output register; in_tready drops only while a held result is not taken.
// Reset (rst_n low, synchronous): mode idle, no digits, hold cleared, stored code back to
//   its default, hold time back to 5 ticks, output register empty.
module keypad_code_lock_unit
  import kcl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CODE_W-1:0]  cfg_data,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IDATA_W-1:0] in_tdata,   // key[3:0], zero fill
  input  logic               in_tuser,   // kind[0]
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [ODATA_W-1:0] out_tdata   // mode[2:0], entered_count[5:3],
                                         // entered_code[29:6], relay_on[30],
                                         // save_strobe[31], saved_code[55:32]
);

  kcl_result_t res;
  logic        step_en;

  assign step_en = in_tvalid && in_tready;

  kcl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step_en   (step_en),
    .kind      (in_tuser),
    .key       (in_tdata[KEY_W-1:0]),
    .res       (res)
  );

  kcl_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (in_tvalid),
    .res_ready  (in_tready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> rtl/core/kcl_core.sv
`timescale 1ns / 1ps

module kcl_core
  import kcl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CODE_W-1:0] cfg_data,
  input  logic              step_en,
  input  logic              kind,
  input  logic [KEY_W-1:0]  key,
  output kcl_result_t       res
);

  logic [MODE_W-1:0] mode_r,  mode_nxt;
  logic [CNT_W-1:0]  cnt_r,   cnt_nxt;
  logic [HOLD_W-1:0] hold_r,  hold_nxt;
  logic [HOLD_W-1:0] hold_sec_r;
  digit_t            digits_r [CODE_DIGITS];
  digit_t            digits_nxt [CODE_DIGITS];
  digit_t            stored_r [CODE_DIGITS];
  digit_t            stored_nxt [CODE_DIGITS];
  logic              save;
  logic              editing;
  logic              match;
  logic [HOLD_W-1:0] hold_inc;
  logic [31:0]       cfg_wide;
  logic [31:0]       rst_wide;
  logic [CNT_W-1:0]  cnt_dec;

  assign cfg_wide = {{(32 - CODE_W){1'b0}}, cfg_data};
  assign rst_wide = {{(32 - CODE_W){1'b0}}, DEFAULT_CODE_RST};
  assign editing  = (mode_r == MODE_ENTRY) || (mode_r == MODE_CHANGE);
  assign hold_inc = hold_r + 1'b1;
  assign cnt_dec  = cnt_r - 1'b1;

  always_comb begin
    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    hold_nxt   = hold_r;
    digits_nxt = digits_r;
    stored_nxt = stored_r;
    save       = 1'b0;
    match      = 1'b1;
    if (kind == KIND_TICK) begin
      if ((mode_r == MODE_OPEN) || (mode_r == MODE_CHANGE) || (mode_r == MODE_FAIL)) begin
        // a hold of zero ends on the first tick, same as one
        if (hold_inc >= hold_sec_r) begin
          mode_nxt = MODE_IDLE;
          cnt_nxt  = '0;
          hold_nxt = '0;
        end else begin
          hold_nxt = hold_inc;
        end
      end
    end else begin
      unique case (key) inside
        [KEY_DIGIT0:KEY_DIGIT9]: begin
          if (mode_r == MODE_CHANGE) hold_nxt = '0;
          if (editing && (cnt_r < CNT_W'(CODE_DIGITS))) begin
            digits_nxt[cnt_r[IDX_W-1:0]] = key;
            cnt_nxt = cnt_r + 1'b1;
            if ((mode_r == MODE_ENTRY) && (cnt_nxt == CNT_W'(CODE_DIGITS))) begin
              for (int k = 0; k < CODE_DIGITS; k++) begin
                if (digits_nxt[k] != stored_r[k]) match = 1'b0;
              end
              mode_nxt = match ? MODE_OPEN : MODE_FAIL;
              hold_nxt = '0;
            end
          end
        end
        KEY_BACK: begin
          if (editing && (cnt_r != '0)) begin
            cnt_nxt = cnt_dec;
            digits_nxt[cnt_dec[IDX_W-1:0]] = '0;
          end
        end
        KEY_CONFIRM: begin
          if (mode_r == MODE_OPEN) begin
            mode_nxt = MODE_CHANGE;
            cnt_nxt  = '0;
            hold_nxt = '0;
          end else if (mode_r == MODE_CHANGE) begin
            hold_nxt = '0;
            if (cnt_r >= CNT_W'(CODE_DIGITS)) begin
              stored_nxt = digits_r;
              save       = 1'b1;
              mode_nxt   = MODE_OPEN;
            end
          end
        end
        KEY_START: begin
          if (mode_r == MODE_IDLE) begin
            mode_nxt = MODE_ENTRY;
            cnt_nxt  = '0;
          end
        end
        KEY_CLEAR: begin
          if (editing) cnt_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.mode               = mode_nxt;
    res.entered_count      = OCNT_W'(cnt_nxt);
    res.entered_code       = '0;
    res.saved_code         = '0;
    for (int k = 0; k < PACK_DIGITS; k++) begin
      if (CNT_W'(k) < cnt_nxt) res.entered_code[DIGIT_W*k +: DIGIT_W] = digits_nxt[k];
      res.saved_code[DIGIT_W*k +: DIGIT_W] = stored_nxt[k];
    end
    res.relay_on    = (mode_nxt == MODE_OPEN) || (mode_nxt == MODE_CHANGE);
    res.save_strobe = save;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      cnt_r      <= '0;
      hold_r     <= '0;
      hold_sec_r <= HOLD_SECONDS_RST;
      for (int k = 0; k < CODE_DIGITS; k++) begin
        digits_r[k] <= '0;
        stored_r[k] <= rst_wide[DIGIT_W*k +: DIGIT_W];
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEFAULT_CODE) begin
        for (int k = 0; k < CODE_DIGITS; k++) begin
          stored_r[k] <= cfg_wide[DIGIT_W*k +: DIGIT_W];
        end
      end else begin
        hold_sec_r <= cfg_data[HOLD_W-1:0];
      end
    end else if (step_en) begin
      mode_r   <= mode_nxt;
      cnt_r    <= cnt_nxt;
      hold_r   <= hold_nxt;
      digits_r <= digits_nxt;
      stored_r <= stored_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CODE_DIGITS))
    else $error("digit count beyond code length");

  a_save_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res.save_strobe) |=> (mode_r == MODE_OPEN))
    else $error("code stored without returning to open");

  a_idle_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && !cfg_we && (mode_r == MODE_IDLE) &&
     !((kind == KIND_KEY) && (key == KEY_START))) |=> (mode_r == MODE_IDLE))
    else $error("left idle without start key");

endmodule

>>> rtl/core/kcl_out_reg.sv
`timescale 1ns / 1ps

module kcl_out_reg
  import kcl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  output logic               res_ready,
  input  kcl_result_t        res,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [ODATA_W-1:0] out_tdata
);

  logic        valid_r;
  kcl_result_t data_r;

  // next word loads as soon as the held one is taken
  assign res_ready  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {data_r.saved_code, data_r.save_strobe, data_r.relay_on,
                       data_r.entered_code, data_r.entered_count, data_r.mode};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) data_r <= res;
  end

endmodule

>>> tb/keypad_code_lock_unit_tb.sv
`timescale 1ns / 1ps

module keypad_code_lock_unit_tb
  import kcl_pkg::*;
;

  localparam int QUIET_LIMIT    = 2000;
  localparam int DIR_ROWS       = 25;
  localparam int PHASES         = 6;
  localparam int WORDS_PER_PHASE = 170;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [OCNT_W-1:0] count;
    logic [CODE_W-1:0] code;
    logic              relay;
    logic              save;
    logic [CODE_W-1:0] saved;
  } lock_view_t;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic             typed;
    lock_view_t       view;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_index;
  logic [CODE_W-1:0]  cfg_data;
  logic               in_tvalid;
  logic               in_tready;
  logic [IDATA_W-1:0] in_tdata;   // key[3:0], zero fill
  logic               in_tuser;   // kind[0]
  logic               out_tvalid;
  logic               out_tready;
  logic [ODATA_W-1:0] out_tdata;  // mode[2:0], entered_count[5:3], entered_code[29:6],
                                  // relay_on[30], save_strobe[31], saved_code[55:32]

  keypad_code_lock_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // lock state as the testbench sees it
  logic [MODE_W-1:0]  lk_mode;
  int                 lk_count;
  logic [DIGIT_W-1:0] lk_entry  [CODE_DIGITS];
  logic [DIGIT_W-1:0] lk_stored [CODE_DIGITS];
  logic [HOLD_W-1:0]  lk_hold;
  logic [HOLD_W-1:0]  cfg_hold;
  bit                 aim_right;

  lock_view_t pending_views[$];
  lock_view_t exp_view;
  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;
  int words_taken;
  int stall_left;
  bit squeeze_done;
  int quiet_cycles;

  function automatic lock_view_t advance_lock(input logic kind, input logic [KEY_W-1:0] key);
    lock_view_t v;
    logic editing;
    logic match;
    logic saving;
    int k;
    saving  = 1'b0;
    editing = (lk_mode == MODE_ENTRY) || (lk_mode == MODE_CHANGE);
    if (kind == KIND_TICK) begin
      if (lk_mode == MODE_OPEN || lk_mode == MODE_CHANGE || lk_mode == MODE_FAIL) begin
        lk_hold = lk_hold + 8'd1;
        // a hold of zero behaves like one
        if (lk_hold >= cfg_hold) begin
          lk_mode  = MODE_IDLE;
          lk_count = 0;
          lk_hold  = '0;
        end
      end
    end else if (key <= KEY_DIGIT9) begin
      if (lk_mode == MODE_CHANGE) lk_hold = '0;
      if (editing && lk_count < CODE_DIGITS) begin
        lk_entry[lk_count] = key;
        lk_count++;
        if (lk_mode == MODE_ENTRY && lk_count == CODE_DIGITS) begin
          match = 1'b1;
          for (k = 0; k < CODE_DIGITS; k++)
            if (lk_entry[k] != lk_stored[k]) match = 1'b0;
          lk_mode = match ? MODE_OPEN : MODE_FAIL;
          lk_hold = '0;
        end
      end
    end else if (key == KEY_BACK) begin
      if (editing && lk_count > 0) begin
        lk_count--;
        lk_entry[lk_count] = '0;
      end
    end else if (key == KEY_CONFIRM) begin
      if (lk_mode == MODE_OPEN) begin
        lk_mode  = MODE_CHANGE;
        lk_count = 0;
        lk_hold  = '0;
      end else if (lk_mode == MODE_CHANGE) begin
        lk_hold = '0;
        if (lk_count >= CODE_DIGITS) begin
          for (k = 0; k < CODE_DIGITS; k++) lk_stored[k] = lk_entry[k];
          saving  = 1'b1;
          lk_mode = MODE_OPEN;
        end
      end
    end else if (key == KEY_START) begin
      if (lk_mode == MODE_IDLE) begin
        lk_mode  = MODE_ENTRY;
        lk_count = 0;
      end
    end else if (key == KEY_CLEAR) begin
      if (editing) lk_count = 0;
    end
    v.mode  = lk_mode;
    v.count = lk_count[OCNT_W-1:0];
    v.code  = '0;
    v.saved = '0;
    for (k = 0; k < PACK_DIGITS; k++) begin
      if (k < lk_count) v.code = v.code | (CODE_W'(lk_entry[k]) << (4 * k));
      v.saved = v.saved | (CODE_W'(lk_stored[k]) << (4 * k));
    end
    v.relay = (lk_mode == MODE_OPEN) || (lk_mode == MODE_CHANGE);
    v.save  = saving;
    return v;
  endfunction

  function automatic dir_row_t pr(input logic kind, input logic [KEY_W-1:0] key);
    dir_row_t r;
    r       = '0;
    r.kind  = kind;
    r.key   = key;
    r.typed = 1'b0;
    return r;
  endfunction

  // typed rows all sit before any new code is saved, with the relay off
  function automatic dir_row_t ty(input logic kind, input logic [KEY_W-1:0] key,
                                  input logic [MODE_W-1:0] mode, input int count,
                                  input logic [CODE_W-1:0] code);
    dir_row_t r;
    r            = '0;
    r.kind       = kind;
    r.key        = key;
    r.typed      = 1'b1;
    r.view.mode  = mode;
    r.view.count = count[OCNT_W-1:0];
    r.view.code  = code;
    r.view.relay = 1'b0;
    r.view.save  = 1'b0;
    r.view.saved = DEFAULT_CODE_RST;
    return r;
  endfunction

  task automatic send_word(input logic kind, input logic [KEY_W-1:0] key,
                           input logic typed, input lock_view_t typed_view);
    lock_view_t v;
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0000, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    v = advance_lock(kind, key);
    pending_views.push_back(typed ? typed_view : v);
  endtask

  // mostly well-formed sessions: start, a guess, open, change code, timeouts
  task automatic pick_word(output logic kind, output logic [KEY_W-1:0] key);
    int r;
    r    = $urandom_range(99);
    kind = 1'($urandom_range(1));
    key  = KEY_W'($urandom_range(15));
    case (lk_mode)
      MODE_IDLE: begin
        if (r < 75) begin
          kind      = KIND_KEY;
          key       = KEY_START;
          aim_right = ($urandom_range(99) < 55);
        end
      end
      MODE_ENTRY: begin
        if (r < 80) begin
          kind = KIND_KEY;
          key  = aim_right ? lk_stored[lk_count] : KEY_W'($urandom_range(9));
        end else if (r < 85) begin
          kind = KIND_KEY;
          key  = KEY_BACK;
        end else if (r < 88) begin
          kind = KIND_KEY;
          key  = KEY_CLEAR;
        end
      end
      MODE_OPEN: begin
        if (r < 45) begin
          kind = KIND_KEY;
          key  = KEY_CONFIRM;
        end else if (r < 75) begin
          kind = KIND_TICK;
        end
      end
      MODE_CHANGE: begin
        if (lk_count >= CODE_DIGITS) begin
          if (r < 50) begin
            kind = KIND_KEY;
            key  = KEY_CONFIRM;
          end else if (r < 65) begin
            kind = KIND_TICK;
          end
        end else if (r < 75) begin
          kind = KIND_KEY;
          key  = KEY_W'($urandom_range(9));
        end else if (r < 82) begin
          kind = KIND_KEY;
          key  = KEY_BACK;
        end else if (r < 85) begin
          kind = KIND_KEY;
          key  = KEY_CLEAR;
        end else if (r < 90) begin
          kind = KIND_KEY;
          key  = KEY_CONFIRM;
        end else if (r < 95) begin
          kind = KIND_TICK;
        end
      end
      default: begin
        if (r < 85) kind = KIND_TICK;
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [CODE_W-1:0] want,
                               input logic [CODE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      words_taken++;
      if (pending_views.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        exp_view = pending_views.pop_front();
        compare_field("mode", exp_view.mode, out_tdata[2:0]);
        compare_field("entered_count", exp_view.count, out_tdata[5:3]);
        compare_field("entered_code", exp_view.code, out_tdata[29:6]);
        compare_field("relay_on", exp_view.relay, out_tdata[30]);
        compare_field("save_strobe", exp_view.save, out_tdata[31]);
        compare_field("saved_code", exp_view.saved, out_tdata[55:32]);
      end
    end
    // one long hold-off so the block backs up into its input
    if (words_taken == 300 && !squeeze_done) begin
      squeeze_done = 1'b1;
      stall_left   = 250;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  dir_row_t          dir_rows [DIR_ROWS];
  logic [CODE_W-1:0] phase_code [PHASES];
  logic [HOLD_W-1:0] phase_hold [PHASES];

  initial begin
    int i;
    int p;
    int k;
    int rnd_sent;
    logic kind;
    logic [KEY_W-1:0] key;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_DEFAULT_CODE;
    cfg_data     = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = KIND_KEY;
    out_tready   = 1'b0;
    mismatches   = 0;
    words_taken  = 0;
    stall_left   = 0;
    squeeze_done = 1'b0;
    quiet_cycles = 0;
    aim_right    = 1'b0;
    rnd_sent     = 0;
    send_idle_pct = 33;
    recv_idle_pct = 46;

    lk_mode  = MODE_IDLE;
    lk_count = 0;
    lk_hold  = '0;
    cfg_hold = HOLD_SECONDS_RST;
    for (k = 0; k < CODE_DIGITS; k++) begin
      lk_entry[k]  = '0;
      lk_stored[k] = (k < 6) ? DEFAULT_CODE_RST[4*k +: 4] : '0;
    end

    dir_rows[0]  = ty(KIND_TICK, KEY_DIGIT0, MODE_IDLE, 0, 24'h0);   // tick while idle
    dir_rows[1]  = ty(KIND_KEY, 4'd15, MODE_IDLE, 0, 24'h0);         // unused key
    dir_rows[2]  = ty(KIND_KEY, KEY_BACK, MODE_IDLE, 0, 24'h0);      // key outside its mode
    dir_rows[3]  = ty(KIND_KEY, KEY_START, MODE_ENTRY, 0, 24'h0);
    dir_rows[4]  = ty(KIND_KEY, KEY_BACK, MODE_ENTRY, 0, 24'h0);     // backspace on empty
    dir_rows[5]  = ty(KIND_TICK, KEY_DIGIT9, MODE_ENTRY, 0, 24'h0);  // tick in entry
    dir_rows[6]  = ty(KIND_KEY, 4'd8, MODE_ENTRY, 1, 24'h8);
    dir_rows[7]  = ty(KIND_KEY, KEY_CLEAR, MODE_ENTRY, 0, 24'h0);
    for (i = 8; i < 14; i++) dir_rows[i] = pr(KIND_KEY, 4'd8);       // default code opens
    dir_rows[14] = pr(KIND_KEY, KEY_CONFIRM);                        // into change
    dir_rows[15] = pr(KIND_TICK, KEY_DIGIT0);
    dir_rows[16] = pr(KIND_KEY, KEY_CONFIRM);                        // not full, hold restarts
    dir_rows[17] = pr(KIND_KEY, KEY_DIGIT0);
    dir_rows[18] = pr(KIND_KEY, KEY_DIGIT9);
    dir_rows[19] = pr(KIND_KEY, 4'd1);
    dir_rows[20] = pr(KIND_KEY, 4'd2);
    dir_rows[21] = pr(KIND_KEY, 4'd3);
    dir_rows[22] = pr(KIND_KEY, 4'd4);
    dir_rows[23] = pr(KIND_KEY, 4'd5);                               // digit when full
    dir_rows[24] = pr(KIND_KEY, KEY_CONFIRM);                        // saves new code

    phase_code[0] = DEFAULT_CODE_RST;
    phase_hold[0] = HOLD_SECONDS_RST;
    phase_code[1] = 24'h000000;
    phase_hold[1] = 8'd1;
    // digits above nine can never be matched
    phase_code[2] = 24'hFFFFFF;
    phase_hold[2] = 8'd255;
    phase_hold[3] = 8'd0;
    phase_hold[4] = 8'd3;
    phase_hold[5] = HOLD_W'($urandom_range(8, 1));
    for (p = 3; p < PHASES; p++) begin
      phase_code[p] = '0;
      for (k = 0; k < 6; k++) phase_code[p][4*k +: 4] = DIGIT_W'($urandom_range(9));
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++)
      send_word(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].view);

    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        in_tvalid <= 1'b0;
        while (pending_views.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEFAULT_CODE;
        cfg_data  <= phase_code[p];
        @(posedge clk);
        cfg_index <= CFG_HOLD_SECONDS;
        cfg_data  <= {16'd0, phase_hold[p]};
        @(posedge clk);
        cfg_we <= 1'b0;
        for (k = 0; k < CODE_DIGITS; k++)
          lk_stored[k] = (k < 6) ? phase_code[p][4*k +: 4] : '0;
        cfg_hold = phase_hold[p];
      end
      for (i = 0; i < WORDS_PER_PHASE; i++) begin
        if (rnd_sent < 340) begin
          send_idle_pct = 33;
          recv_idle_pct = 46;
        end else if (rnd_sent < 680) begin
          send_idle_pct = 46;
          recv_idle_pct = 33;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        pick_word(kind, key);
        send_word(kind, key, 1'b0, '0);
        rnd_sent++;
      end
    end

    in_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
